[hw/rtl/srdfa_pkg.sv]
// Shared types, field widths and request codes of the sparse-row DFA matcher.
`timescale 1ns / 1ps

package srdfa_pkg;

  // Field widths fixed by the request and result formats.
  localparam int KIND_W  = 3;
  localparam int STATE_W = 6;
  localparam int IDX_W   = 8;
  localparam int SYM_W   = 8;
  localparam int POS_W   = 32;

  // Default table geometry.
  localparam int NUM_STATES_DEF  = 64;
  localparam int ROW_ENTRIES_DEF = 256;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE_ENTRY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_ACCEPT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESET_STATE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEW_STRING   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DATA         = 3'd4;

  // Input request payload.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] state_index;
    logic [IDX_W-1:0]   entry_index;
    logic [SYM_W-1:0]   entry_symbol;
    logic [STATE_W-1:0] entry_next;
    logic               accept_value;
    logic [SYM_W-1:0]   data_byte;
  } srdfa_in_t;

  // Result payload.
  typedef struct packed {
    logic               accepting;
    logic [STATE_W-1:0] current_state;
    logic               found;
    logic [POS_W-1:0]   first_position;
  } srdfa_out_t;

  // Control from the sequencer to the row compare unit.
  typedef struct packed {
    logic start;
    logic valid;
  } scan_ctrl_t;

  // Status from the row compare unit back to the sequencer.
  typedef struct packed {
    logic               has_match;
    logic [STATE_W-1:0] match_next;
    logic               has_def;
    logic [STATE_W-1:0] def_next;
  } scan_stat_t;

endpackage

[hw/rtl/srdfa_if.sv]
// Valid/ready channel interfaces for requests and results of the DFA matcher.
`timescale 1ns / 1ps

interface srdfa_in_if;
  logic                  valid;
  logic                  ready;
  srdfa_pkg::srdfa_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srdfa_out_if;
  logic                  valid;
  logic                  ready;
  srdfa_pkg::srdfa_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/srdfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module srdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/srdfa_scan.sv]
// Row compare unit: checks one table entry per cycle against the data byte.
`timescale 1ns / 1ps

module srdfa_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srdfa_pkg::scan_ctrl_t            ctrl_i,
  input  logic [srdfa_pkg::SYM_W-1:0]      byte_i,
  input  logic [srdfa_pkg::SYM_W-1:0]      sym_i,
  input  logic [srdfa_pkg::STATE_W-1:0]    next_i,
  output srdfa_pkg::scan_stat_t            stat_o
);
  import srdfa_pkg::*;

  logic               has_match_q, has_match_d;
  logic               has_def_q, has_def_d;
  logic [STATE_W-1:0] match_next_q, match_next_d;
  logic [STATE_W-1:0] def_next_q, def_next_d;
  logic               hit_byte;
  logic               hit_def;

  // The shared comparators.
  assign hit_byte = (sym_i == byte_i);
  assign hit_def  = (sym_i == '0);

  // The last matching entry wins; the first default entry wins.
  always_comb begin
    has_match_d  = has_match_q;
    has_def_d    = has_def_q;
    match_next_d = match_next_q;
    def_next_d   = def_next_q;
    if (ctrl_i.start) begin
      has_match_d = 1'b0;
      has_def_d   = 1'b0;
    end else if (ctrl_i.valid) begin
      if (hit_byte) begin
        has_match_d  = 1'b1;
        match_next_d = next_i;
      end
      if (hit_def && !has_def_q) begin
        has_def_d  = 1'b1;
        def_next_d = next_i;
      end
    end
  end

  // Flags need a reset; the captured next states do not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_match_q <= 1'b0;
      has_def_q   <= 1'b0;
    end else begin
      has_match_q <= has_match_d;
      has_def_q   <= has_def_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_next_q <= match_next_d;
    def_next_q   <= def_next_d;
  end

  assign stat_o.has_match  = has_match_q;
  assign stat_o.match_next = match_next_q;
  assign stat_o.has_def    = has_def_q;
  assign stat_o.def_next   = def_next_q;

endmodule

[hw/rtl/sparse_row_dfa_matcher.sv]
// Top level of the sparse-row DFA matcher: sequencer, table stores and string tracking.
`timescale 1ns / 1ps

// Usage:
// Requests enter on in_i (valid/ready); a request is taken at a clock edge
// where both are high. Table entry and accept flag writes, state reset and
// new-string requests take effect when taken and give no result. A data
// byte request gives exactly one result on out_o (valid/ready).
// A data byte scans the current state's row through one table read port,
// one entry per cycle, into a shared compare unit. After the byte is taken,
// the sequencer steps through the scan, drain, accept-flag read and result
// states; a state outside the table skips the scan. The input is not ready
// meanwhile. Results sit in an output register. When the receiver stalls,
// the block still takes non-data requests; a new data byte holds in its
// result cycle until the output register is free.
// After reset, a clearing pass zeroes the table and the accept flags, one
// entry per cycle, over all NUM_STATES * ROW_ENTRIES table entries. No
// request is taken during that pass.
module sparse_row_dfa_matcher #(
  parameter int NUM_STATES  = srdfa_pkg::NUM_STATES_DEF,
  parameter int ROW_ENTRIES = srdfa_pkg::ROW_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srdfa_in_if.sink    in_i,
  srdfa_out_if.source out_o
);
  import srdfa_pkg::*;

  localparam int SW    = $clog2(NUM_STATES);
  localparam int EW    = (ROW_ENTRIES > 1) ? $clog2(ROW_ENTRIES) : 1;
  localparam int DEPTH = NUM_STATES * ROW_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = SYM_W + STATE_W;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FLAG  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic [EW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      base_q, base_d;
  logic [SYM_W-1:0]   byte_q, byte_d;
  logic [STATE_W-1:0] cur_q, cur_d;
  logic               rd_vld_q;
  logic [POS_W-1:0]   byte_cnt_q, byte_cnt_d;
  logic               found_q, found_d;
  logic [POS_W-1:0]   first_pos_q, first_pos_d;
  logic               out_valid_q, out_valid_d;
  srdfa_out_t         out_q, out_d;

  logic               in_fire;
  logic               out_free;
  logic               cur_in_range;
  logic               wr_state_ok;
  logic               wr_entry_ok;
  logic [STATE_W-1:0] next_state;
  logic               acc;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [TW-1:0]      tbl_wdata;
  logic [AW-1:0]      tbl_raddr;
  logic [TW-1:0]      tbl_rdata;
  logic               acc_we;
  logic [SW-1:0]      acc_waddr;
  logic               acc_wdata;
  logic               acc_rdata;

  scan_ctrl_t         scan_ctrl;
  scan_stat_t         scan_stat;

  // Handshake and range checks.
  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign out_free     = !out_valid_q || out_o.ready;
  assign cur_in_range = (32'(cur_q) < NUM_STATES);
  assign wr_state_ok  = (32'(in_i.data.state_index) < NUM_STATES);
  assign wr_entry_ok  = (32'(in_i.data.entry_index) < ROW_ENTRIES);

  // Table store: cleared by the sweep, loaded by entry writes.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = AW'(32'(in_i.data.state_index) * ROW_ENTRIES
                    + 32'(in_i.data.entry_index));
    tbl_wdata = {in_i.data.entry_symbol, in_i.data.entry_next};
    if (state_q == ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_cnt_q;
      tbl_wdata = '0;
    end else if (in_fire && in_i.data.kind == KIND_WRITE_ENTRY) begin
      tbl_we = wr_state_ok && wr_entry_ok;
    end
  end

  assign tbl_raddr = base_q + AW'(idx_q);

  srdfa_ram #(
    .WIDTH(TW),
    .DEPTH(DEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Accept flag store: cleared while the sweep counter is below NUM_STATES, loaded by accept writes.
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = SW'(in_i.data.state_index);
    acc_wdata = in_i.data.accept_value;
    if (state_q == ST_CLEAR) begin
      acc_we    = (32'(clr_cnt_q) < NUM_STATES);
      acc_waddr = SW'(clr_cnt_q);
      acc_wdata = 1'b0;
    end else if (in_fire && in_i.data.kind == KIND_WRITE_ACCEPT) begin
      acc_we = wr_state_ok;
    end
  end

  srdfa_ram #(
    .WIDTH(1),
    .DEPTH(NUM_STATES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (SW'(next_state)),
    .rdata_o (acc_rdata)
  );

  // Row compare unit fed by the registered table read.
  assign scan_ctrl.start = in_fire && (in_i.data.kind == KIND_DATA);
  assign scan_ctrl.valid = rd_vld_q;

  srdfa_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .byte_i (byte_q),
    .sym_i  (tbl_rdata[TW-1:STATE_W]),
    .next_i (tbl_rdata[STATE_W-1:0]),
    .stat_o (scan_stat)
  );

  // Last match first, then the default entry, else stay.
  always_comb begin
    if (scan_stat.has_match) begin
      next_state = scan_stat.match_next;
    end else if (scan_stat.has_def) begin
      next_state = scan_stat.def_next;
    end else begin
      next_state = cur_q;
    end
  end

  assign acc = cur_in_range && acc_rdata;

  // Sequencer and string tracking.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    idx_d       = idx_q;
    base_d      = base_q;
    byte_d      = byte_q;
    cur_d       = cur_q;
    byte_cnt_d  = byte_cnt_q;
    found_d     = found_q;
    first_pos_d = first_pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (32'(clr_cnt_q) == DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.data.kind)
            KIND_RESET_STATE: begin
              cur_d = '0;
            end
            KIND_NEW_STRING: begin
              byte_cnt_d  = '0;
              found_d     = 1'b0;
              first_pos_d = '0;
            end
            KIND_DATA: begin
              byte_d = in_i.data.data_byte;
              idx_d  = '0;
              base_d = AW'(32'(cur_q) * ROW_ENTRIES);
              // A state outside the table has an empty row.
              state_d = cur_in_range ? ST_SCAN : ST_FLAG;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (32'(idx_q) == ROW_ENTRIES - 1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FLAG;
      end
      ST_FLAG: begin
        cur_d   = next_state;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          if (acc && !found_q) begin
            found_d     = 1'b1;
            first_pos_d = byte_cnt_q;
          end
          if (byte_cnt_q != '1) begin
            byte_cnt_d = byte_cnt_q + 1'b1;
          end
          out_d.accepting      = acc;
          out_d.current_state  = cur_q;
          out_d.found          = found_q || acc;
          out_d.first_position = found_q ? first_pos_q : (acc ? byte_cnt_q : '0);
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      cur_q       <= '0;
      byte_cnt_q  <= '0;
      found_q     <= 1'b0;
      first_pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      idx_q       <= idx_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      cur_q       <= cur_d;
      byte_cnt_q  <= byte_cnt_d;
      found_q     <= found_d;
      first_pos_q <= first_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // The first accepting position always lies behind the byte counter, unless the counter has saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (first_pos_q < byte_cnt_q) || (byte_cnt_q == '1))
    else $error("first accepting position not behind byte counter");

  // Without a hit the recorded position stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (first_pos_q == '0))
    else $error("position recorded without an accepting byte");

  // A result only appears out of the result cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the result cycle");

  // Table reads during a scan stay within the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (32'(tbl_raddr) < DEPTH))
    else $error("scan address beyond the table");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the sparse-row DFA matcher: predicts every match result.
`timescale 1ns / 1ps

module testbench;
  import srdfa_pkg::*;

  // Cycles without progress before the run is declared hung; the clearing pass
  // after reset also counts as a stretch without progress.
  localparam int QUIET_LIMIT = 50000;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 2000;
  // Cycles to watch for stray results once everything has drained.
  localparam int TAIL_CYCLES = 300;
  // Minimum number of requests per random phase.
  localparam int PHASE_REQS  = 180;
  localparam int KIND_MAX    = (1 << KIND_W) - 1;

  bit   clk = 1'b0;
  logic rst_n;

  srdfa_in_if  req_if ();
  srdfa_out_if res_if ();

  sparse_row_dfa_matcher u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always begin
    #6 clk = ~clk;
  end

  // Requests waiting to be offered and results the matcher still owes.
  srdfa_in_t  request_backlog [$];
  srdfa_out_t results_due [$];

  // Shadow copy of the matcher: transition table, accept flags, string tracking.
  bit [SYM_W-1:0]   row_sym [NUM_STATES_DEF][ROW_ENTRIES_DEF];
  bit [STATE_W-1:0] row_nxt [NUM_STATES_DEF][ROW_ENTRIES_DEF];
  bit               accept_flag [NUM_STATES_DEF];
  bit [STATE_W-1:0] dfa_state;
  bit [POS_W-1:0]   byte_pos;
  bit               seen_accept;
  bit [POS_W-1:0]   first_pos;

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_trigger;
  int hold_seen;
  int hold_cnt;
  int quiet_cycles;
  // A request is on offer while more have been offered than taken.
  int offered_cnt;
  int taken_cnt;

  // Apply one accepted request to the shadow matcher and queue any result it owes.
  function automatic void step_dfa(srdfa_in_t req);
    logic               hit;
    logic               dflt;
    logic [STATE_W-1:0] hit_next;
    logic [STATE_W-1:0] dflt_next;
    srdfa_out_t         res;
    case (req.kind)
      KIND_WRITE_ENTRY: begin
        row_sym[req.state_index][req.entry_index] = req.entry_symbol;
        row_nxt[req.state_index][req.entry_index] = req.entry_next;
      end
      KIND_WRITE_ACCEPT: begin
        accept_flag[req.state_index] = req.accept_value;
      end
      KIND_RESET_STATE: begin
        dfa_state = '0;
      end
      KIND_NEW_STRING: begin
        byte_pos    = '0;
        seen_accept = 1'b0;
        first_pos   = '0;
      end
      KIND_DATA: begin
        hit       = 1'b0;
        dflt      = 1'b0;
        hit_next  = '0;
        dflt_next = '0;
        // Last exact match wins; the first zero-symbol entry is the fallback.
        for (int i = 0; i < ROW_ENTRIES_DEF; i++) begin
          if (row_sym[dfa_state][i] == req.data_byte) begin
            hit      = 1'b1;
            hit_next = row_nxt[dfa_state][i];
          end
          if (row_sym[dfa_state][i] == '0 && !dflt) begin
            dflt      = 1'b1;
            dflt_next = row_nxt[dfa_state][i];
          end
        end
        if (hit) begin
          dfa_state = hit_next;
        end else if (dflt) begin
          dfa_state = dflt_next;
        end
        res.accepting = accept_flag[dfa_state];
        if (res.accepting && !seen_accept) begin
          seen_accept = 1'b1;
          first_pos   = byte_pos;
        end
        if (byte_pos != '1) begin
          byte_pos++;
        end
        res.current_state  = dfa_state;
        res.found          = seen_accept;
        res.first_position = seen_accept ? first_pos : '0;
        results_due.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  // A request with every field random; callers overwrite what matters.
  function automatic srdfa_in_t noise_request();
    logic [63:0]                  wide;
    logic [$bits(srdfa_in_t)-1:0] raw;
    wide = {$urandom(), $urandom()};
    raw  = wide[$bits(srdfa_in_t)-1:0];
    return srdfa_in_t'(raw);
  endfunction

  function automatic void put_ctrl(int kind);
    srdfa_in_t r;
    r      = noise_request();
    r.kind = KIND_W'(kind);
    request_backlog.push_back(r);
  endfunction

  function automatic void put_byte(int b);
    srdfa_in_t r;
    r           = noise_request();
    r.kind      = KIND_DATA;
    r.data_byte = SYM_W'(b);
    request_backlog.push_back(r);
  endfunction

  function automatic void wr_entry(int s, int e, int sym, int nxt);
    srdfa_in_t r;
    r              = noise_request();
    r.kind         = KIND_WRITE_ENTRY;
    r.state_index  = STATE_W'(s);
    r.entry_index  = IDX_W'(e);
    r.entry_symbol = SYM_W'(sym);
    r.entry_next   = STATE_W'(nxt);
    request_backlog.push_back(r);
  endfunction

  function automatic void wr_accept(int s, int v);
    srdfa_in_t r;
    r              = noise_request();
    r.kind         = KIND_WRITE_ACCEPT;
    r.state_index  = STATE_W'(s);
    r.accept_value = v[0];
    request_backlog.push_back(r);
  endfunction

  // A small automaton over a few states and a short alphabet, then a string
  // fed through it with occasional restarts and stray requests.
  function automatic int gen_program();
    int         states [6];
    logic [7:0] alpha [5];
    int         n;
    int         pick;
    n = 0;
    foreach (states[i]) states[i] = $urandom_range(NUM_STATES_DEF - 1);
    if ($urandom_range(9) < 7) states[0] = 0;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
    if ($urandom_range(9) < 3) alpha[0] = '0;
    repeat ($urandom_range(4, 16)) begin
      wr_entry(states[$urandom_range(5)],
               ($urandom_range(9) < 6) ? $urandom_range(3) : $urandom_range(255),
               alpha[$urandom_range(4)], states[$urandom_range(5)]);
      n++;
    end
    repeat ($urandom_range(1, 4)) begin
      wr_accept(states[$urandom_range(5)], $urandom_range(1));
      n++;
    end
    if ($urandom_range(9) < 5) begin
      put_ctrl(KIND_RESET_STATE);
      n++;
    end
    if ($urandom_range(9) < 6) begin
      put_ctrl(KIND_NEW_STRING);
      n++;
    end
    repeat ($urandom_range(8, 30)) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        put_ctrl(KIND_NEW_STRING);
      end else if (pick < 7) begin
        put_ctrl(KIND_RESET_STATE);
      end else if (pick < 12) begin
        request_backlog.push_back(noise_request());
      end else if (pick < 27) begin
        put_byte($urandom_range(255));
      end else begin
        put_byte(alpha[$urandom_range(4)]);
      end
      n++;
    end
    return n;
  endfunction

  // Fill one row completely with nonzero symbols so that it has no default
  // entry, steer into it, feed a zero byte, which finds no entry, then random bytes.
  function automatic int gen_full_row();
    int fill_state;
    int steer_sym;
    fill_state = $urandom_range(1, NUM_STATES_DEF - 1);
    steer_sym  = $urandom_range(1, 255);
    for (int e = 0; e < ROW_ENTRIES_DEF; e++) begin
      wr_entry(fill_state, e, $urandom_range(1, 255), $urandom_range(NUM_STATES_DEF - 1));
    end
    wr_accept(fill_state, 1);
    put_ctrl(KIND_RESET_STATE);
    wr_entry(0, ROW_ENTRIES_DEF - 1, steer_sym, fill_state);
    put_byte(steer_sym);
    put_byte(0);
    repeat (16) put_byte($urandom_range(255));
    return ROW_ENTRIES_DEF + 20;
  endfunction

  // Wait until every request is taken and every result has come back.
  task automatic drain();
    while (request_backlog.size() > 0 || results_due.size() > 0) @(posedge clk);
  endtask

  // Offer requests from the backlog; an offered request stays up until taken.
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (offered_cnt == taken_cnt) begin
      if (request_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data  <= request_backlog[0];
        offered_cnt++;
      end else begin
        req_if.valid <= 1'b0;
        req_if.data  <= noise_request();
      end
    end
  end

  // Take accepted requests into the shadow matcher.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && req_if.valid && req_if.ready) begin
      step_dfa(req_if.data);
      void'(request_backlog.pop_front());
      taken_cnt++;
    end
  end

  // Result-side ready: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(string what, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each returned result with the oldest one owed.
  always @(posedge clk) begin : result_check
    srdfa_out_t due;
    if (rst_n === 1'b1 && res_if.valid && res_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got state %0d pos %0d",
                 $time, res_if.data.current_state, res_if.data.first_position);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        check_field("accepting", due.accepting, res_if.data.accepting);
        check_field("current_state", due.current_state, res_if.data.current_state);
        check_field("found", due.found, res_if.data.found);
        check_field("first_position", due.first_position, res_if.data.first_position);
      end
    end
  end

  // Hang detection: count cycles with work outstanding but no handshake.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
        || (request_backlog.size() == 0 && results_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int made;
    rst_n = 1'b0;

    // Directed: empty table, last match and first default, zero byte,
    // state reset, new string, reserved kinds and field extremes.
    put_byte(8'h00);
    put_byte(8'hFF);
    wr_entry(0, 0, 8'hFF, NUM_STATES_DEF - 1);
    wr_entry(0, ROW_ENTRIES_DEF - 1, 8'hFF, 5);
    wr_accept(5, 1);
    wr_accept(NUM_STATES_DEF - 1, 1);
    put_byte(8'hFF);
    wr_entry(5, 0, 8'h01, NUM_STATES_DEF - 1);
    wr_entry(5, ROW_ENTRIES_DEF - 1, 8'h00, NUM_STATES_DEF - 1);
    put_byte(8'h7E);
    put_ctrl(KIND_NEW_STRING);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_ctrl(KIND_RESET_STATE);
    put_byte(8'h01);
    for (int k = KIND_DATA + 1; k <= KIND_MAX; k++) put_ctrl(k);
    wr_accept(NUM_STATES_DEF - 1, 0);
    wr_accept(0, 1);
    put_byte(8'h80);
    put_ctrl(KIND_NEW_STRING);
    put_byte(8'h80);
    wr_accept(0, 0);
    put_byte(8'hFF);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    // Random phases under different idling mixes.
    for (int round = 0; round < 2; round++) begin
      for (int mode = 0; mode < 4; mode++) begin
        send_idle_pct  = (mode == 1) ? 49 : (mode == 3) ? 16 : 0;
        recv_stall_pct = (mode == 2) ? 49 : (mode == 3) ? 16 : 0;
        made = 0;
        if (round == 0 && mode == 1) made += gen_full_row();
        while (made < PHASE_REQS) made += gen_program();
        drain();

        // Back-pressure: hold results off while requests keep coming.
        if (round == 0 && mode == 0) begin
          hold_trigger++;
          made = 0;
          while (made < 40) made += gen_program();
          drain();
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/srdfa_pkg.sv
hw/rtl/srdfa_if.sv
hw/rtl/srdfa_ram.sv
hw/rtl/srdfa_scan.sv
hw/rtl/sparse_row_dfa_matcher.sv
sim/testbench.sv
